/* sv/wrc_pkg.sv */
// ----------------------------------------------------------------------------
// wrc_pkg
// Shared types, widths and codes for the wheel rpm capture block.
// ----------------------------------------------------------------------------
`default_nettype none

package wrc_pkg;

  // wheel and counter geometry
  localparam int NUM_WHEELS   = 4;
  localparam int WHEEL_BITS   = 2;
  localparam int COUNTER_BITS = 16;

  // configuration register widths and reset values
  localparam int CLK_HZ_BITS  = 28;
  localparam int PPR_BITS     = 8;
  localparam int TIMEOUT_BITS = 16;
  localparam int CFG_DATA_BITS = 28;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic [CLK_HZ_BITS-1:0]  CLK_HZ_RESET  = CLK_HZ_BITS'(1000000);
  localparam logic [PPR_BITS-1:0]     PPR_RESET     = PPR_BITS'(1);
  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = TIMEOUT_BITS'(2000);

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_CLOCK_HZ = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PULSES   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TIMEOUT  = 2'd2;

  // item commands
  localparam logic CMD_CAPTURE = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  // rpm arithmetic: num = 60 * clock, den = diff * pulses
  localparam int RPM_BITS   = 16;
  localparam int SEC_PER_MIN = 60;
  localparam int NUM_BITS   = CLK_HZ_BITS + 6;
  localparam int DIFF_BITS  = COUNTER_BITS + 1;
  localparam int DEN_BITS   = DIFF_BITS + PPR_BITS;
  localparam int NUM_HI_BITS = NUM_BITS - RPM_BITS;
  localparam int DIV_STEPS  = RPM_BITS;
  localparam int STEP_BITS  = $clog2(DIV_STEPS);
  localparam logic [RPM_BITS-1:0] RPM_MAX = '1;

  typedef struct packed {
    logic                    cmd;
    logic [WHEEL_BITS-1:0]   wheel_channel;
    logic [COUNTER_BITS-1:0] capture_value;
  } item_t;

  typedef struct packed {
    logic [RPM_BITS-1:0] rpm_front_right;
    logic [RPM_BITS-1:0] rpm_front_left;
    logic [RPM_BITS-1:0] rpm_rear_right;
    logic [RPM_BITS-1:0] rpm_rear_left;
    logic                timed_out;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic prep;
    logic init_div;
    logic step_div;
    logic commit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic new_is_tick;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

/* sv/wrc_ctrl.sv */
// ----------------------------------------------------------------------------
// wrc_ctrl
// Sequencer: accepts one item, steps a capture through operand setup, the
// shift-subtract divide and final commit to the result; ticks only commit.
// ----------------------------------------------------------------------------
`default_nettype none

module wrc_ctrl
  import wrc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]           state;
  logic [2:0]           state_next;
  logic [STEP_BITS-1:0] step;
  logic [STEP_BITS-1:0] step_next;
  logic                 accept;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && (state == S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_next   = state;
    step_next    = step;
    cmd          = '0;
    cmd.load_item = accept;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = status.new_is_tick ? S_DONE : S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        cmd.init_div = 1'b1;
        step_next    = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.step_div = 1'b1;
        step_next    = step + 1'b1;
        if (step == STEP_BITS'(DIV_STEPS - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        cmd.commit = status.out_free;
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

`default_nettype wire

/* sv/wrc_datapath.sv */
// ----------------------------------------------------------------------------
// wrc_datapath
// Configuration registers, per-wheel capture and rpm state, operand setup,
// radix-2 restoring divider and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wrc_datapath
  import wrc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire item_t                    item,
  input  wire logic                     result_stall,
  output logic                          result_valid,
  output result_t                       result,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
  input  wire ctrl_cmd_t                cmd,
  output dp_status_t                    status
);

  logic [CLK_HZ_BITS-1:0]  clk_hz;
  logic [PPR_BITS-1:0]     ppr;
  logic [TIMEOUT_BITS-1:0] timeout;

  item_t                   item_q;
  logic [COUNTER_BITS-1:0] prev_cap [NUM_WHEELS];
  logic [RPM_BITS-1:0]     rpm      [NUM_WHEELS];
  logic [TIMEOUT_BITS-1:0] idle_cnt;

  logic [NUM_BITS-1:0]     num;
  logic [DEN_BITS-1:0]     den;
  logic [DEN_BITS-1:0]     rem;
  logic [RPM_BITS-1:0]     quot;
  logic                    sat;

  logic [COUNTER_BITS-1:0] diff;
  logic [DIFF_BITS-1:0]    diff_ext;
  logic [DEN_BITS:0]       trial;
  logic                    trial_ge;
  logic [RPM_BITS-1:0]     rpm_calc;
  logic [TIMEOUT_BITS-1:0] idle_inc;
  logic [TIMEOUT_BITS-1:0] limit;
  logic                    hit_timeout;
  logic [RPM_BITS-1:0]     rpm_next [NUM_WHEELS];

  assign status.new_is_tick = (item.cmd == CMD_TICK);
  assign status.out_free    = !result_valid || !result_stall;

  // configuration writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      clk_hz  <= CLK_HZ_RESET;
      ppr     <= PPR_RESET;
      timeout <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CLOCK_HZ: clk_hz  <= cfg_data[CLK_HZ_BITS-1:0];
        REG_PULSES:   ppr     <= cfg_data[PPR_BITS-1:0];
        REG_TIMEOUT:  timeout <= cfg_data[TIMEOUT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // wrapped capture delta, equal capture counts as a full counter period
  assign diff     = item_q.capture_value - prev_cap[item_q.wheel_channel];
  assign diff_ext = (diff == '0) ? (DIFF_BITS'(1) << COUNTER_BITS)
                                 : {1'b0, diff};

  // one restoring divide step
  assign trial    = {rem, quot[RPM_BITS-1]};
  assign trial_ge = (trial >= {1'b0, den});

  // operand setup and divider
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_q <= item;
    end
    if (cmd.prep) begin
      num <= NUM_BITS'(clk_hz) * NUM_BITS'(SEC_PER_MIN);
      den <= DEN_BITS'(diff_ext) * DEN_BITS'(ppr);
    end
    if (cmd.init_div) begin
      // quotient overflows 16 bits exactly when the high part reaches den
      sat  <= (DEN_BITS'(num[NUM_BITS-1:RPM_BITS]) >= den);
      rem  <= DEN_BITS'(num[NUM_BITS-1:RPM_BITS]);
      quot <= num[RPM_BITS-1:0];
    end else if (cmd.step_div) begin
      rem  <= trial_ge ? DEN_BITS'(trial - {1'b0, den}) : trial[DEN_BITS-1:0];
      quot <= {quot[RPM_BITS-2:0], trial_ge};
    end
  end

  // commit values for the item in hand
  assign rpm_calc    = sat ? RPM_MAX : quot;
  assign idle_inc    = idle_cnt + 1'b1;
  assign limit       = (timeout == '0) ? TIMEOUT_BITS'(1) : timeout;
  assign hit_timeout = (item_q.cmd == CMD_TICK) && (idle_inc >= limit);

  always_comb begin
    for (int w = 0; w < NUM_WHEELS; w++) begin
      if (hit_timeout) begin
        rpm_next[w] = '0;
      end else if ((item_q.cmd == CMD_CAPTURE) &&
                   (item_q.wheel_channel == WHEEL_BITS'(w))) begin
        rpm_next[w] = rpm_calc;
      end else begin
        rpm_next[w] = rpm[w];
      end
    end
  end

  // wheel state and idle counter
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < NUM_WHEELS; w++) begin
        prev_cap[w] <= '0;
        rpm[w]      <= '0;
      end
      idle_cnt <= '0;
    end else if (cmd.commit) begin
      for (int w = 0; w < NUM_WHEELS; w++) begin
        rpm[w] <= rpm_next[w];
      end
      if (item_q.cmd == CMD_CAPTURE) begin
        prev_cap[item_q.wheel_channel] <= item_q.capture_value;
        idle_cnt <= '0;
      end else begin
        idle_cnt <= hit_timeout ? '0 : idle_inc;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.commit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result.rpm_front_right <= rpm_next[0];
      result.rpm_front_left  <= rpm_next[1];
      result.rpm_rear_right  <= rpm_next[2];
      result.rpm_rear_left   <= rpm_next[3];
      result.timed_out       <= hit_timeout;
    end
  end

endmodule

`default_nettype wire

/* sv/wheel_rpm_from_capture.sv */
// ----------------------------------------------------------------------------
// wheel_rpm_from_capture
// Four-wheel rpm from input capture timestamps, with idle timeout.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_stall / item): a capture beat carries a
//   wheel index and a 16-bit timer value, a tick beat advances idle time.
//   result channel (result_valid / result_stall / result): one beat per item
//   with the four wheel rpms after the update and the timeout flag.
//   cfg port (cfg_we / cfg_index / cfg_data): clock rate, pulses per
//   revolution and timeout, to be written by the user only while no item is
//   in flight; the block itself does not enforce this.
// A capture goes from accept to result through operand setup, an overflow
// check and a 16-step shift-subtract divide, one quotient bit per cycle.
// A tick skips operand setup and the divide. One item is in work at a time.
// Reset clears all captures, rpms and the idle count and loads the register
// defaults. When the receiver stalls, the result holds in its register; one
// more item may be accepted and worked on, then waits until the result leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module wheel_rpm_from_capture
  import wrc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     item_valid,
  output logic                          item_stall,
  input  wire item_t                    item,
  output logic                          result_valid,
  input  wire logic                     result_stall,
  output result_t                       result,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  wrc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  wrc_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

`default_nettype wire

/* sv/wrc_checker.sv */
// ----------------------------------------------------------------------------
// wrc_checker
// Port-level checks of the wheel rpm block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wrc_checker
  import wrc_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    item_valid,
  input wire logic    item_stall,
  input wire logic    result_valid,
  input wire logic    result_stall,
  input wire result_t result
);

  // no result beat right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // a timeout beat shows every wheel at zero
  a_timeout_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.timed_out) |->
      (result.rpm_front_right == '0) && (result.rpm_front_left == '0) &&
      (result.rpm_rear_right == '0) && (result.rpm_rear_left == '0))
    else $error("timeout beat with nonzero rpm");

  // one item in work at a time: an accepted beat blocks the next cycle
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("item accepted back to back");

  // a stalled result beat holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");

endmodule

bind wheel_rpm_from_capture wrc_checker u_wrc_checker (.*);

`default_nettype wire

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for wheel_rpm_from_capture. A short table of directed
// capture, tick and register beats is followed by random traffic over several
// register settings. Each result beat is scored against a typed row's result
// or an rpm predictor of all four wheels' captures, rpms and idle count.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import wrc_pkg::*;

  localparam int NUM_PHASES      = 7;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 24;
  localparam int WDOG_LIMIT      = 3000;
  localparam int GAP_PCT         = 14;

  // index with no register behind it
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic                     is_reg;
    logic                     typed;
    item_t                    it;
    result_t                  want;
    logic [CFG_IDX_BITS-1:0]  idx;
    logic [CFG_DATA_BITS-1:0] data;
  } dir_row_t;

  logic                     clk;
  logic                     rst;
  logic                     item_valid;
  logic                     item_stall;
  item_t                    item;
  logic                     result_valid;
  logic                     result_stall;
  result_t                  result;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  // predictor copy of registers and wheel state
  logic [CLK_HZ_BITS-1:0]  hz_cfg;
  logic [PPR_BITS-1:0]     ppr_cfg;
  logic [TIMEOUT_BITS-1:0] tmo_cfg;
  logic [COUNTER_BITS-1:0] cap_prev [NUM_WHEELS];
  logic [RPM_BITS-1:0]     rpm_now  [NUM_WHEELS];
  logic [TIMEOUT_BITS-1:0] idle_ticks;

  result_t  rpm_expect_q [$];
  dir_row_t dir_rows [$];

  bit gaps_on  = 1'b1;
  bit hold_req = 1'b0;
  int err_cnt   = 0;
  int n_capture = 0;
  int n_tick    = 0;
  int n_timeout = 0;
  int n_setting = 0;
  int quiet_cnt = 0;

  wheel_rpm_from_capture u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic item_t mk_item(input logic cmd, input logic [WHEEL_BITS-1:0] ch,
                                    input logic [COUNTER_BITS-1:0] cap);
    item_t it;
    it.cmd           = cmd;
    it.wheel_channel = ch;
    it.capture_value = cap;
    return it;
  endfunction

  function automatic result_t mk_result(input logic [RPM_BITS-1:0] fr,
                                        input logic [RPM_BITS-1:0] fl,
                                        input logic [RPM_BITS-1:0] rr,
                                        input logic [RPM_BITS-1:0] rl,
                                        input logic tout);
    result_t r;
    r.rpm_front_right = fr;
    r.rpm_front_left  = fl;
    r.rpm_rear_right  = rr;
    r.rpm_rear_left   = rl;
    r.timed_out       = tout;
    return r;
  endfunction

  function automatic dir_row_t row_item(input item_t it);
    dir_row_t r;
    r    = '0;
    r.it = it;
    return r;
  endfunction

  function automatic dir_row_t row_typed(input item_t it, input result_t want);
    dir_row_t r;
    r       = '0;
    r.typed = 1'b1;
    r.it    = it;
    r.want  = want;
    return r;
  endfunction

  function automatic dir_row_t row_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                       input logic [CFG_DATA_BITS-1:0] data);
    dir_row_t r;
    r        = '0;
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    return r;
  endfunction

  function automatic void rpm_state_reset();
    hz_cfg     = CLK_HZ_RESET;
    ppr_cfg    = PPR_RESET;
    tmo_cfg    = TIMEOUT_RESET;
    idle_ticks = '0;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      cap_prev[i] = '0;
      rpm_now[i]  = '0;
    end
  endfunction

  // register write as the block sees it; upper data bits are dropped
  function automatic void apply_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                    input logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      REG_CLOCK_HZ: hz_cfg  = data[CLK_HZ_BITS-1:0];
      REG_PULSES:   ppr_cfg = data[PPR_BITS-1:0];
      REG_TIMEOUT:  tmo_cfg = data[TIMEOUT_BITS-1:0];
      default: ;
    endcase
  endfunction

  // advance the wheel state by one beat and return the rpm snapshot
  function automatic result_t predict_rpm_update(input item_t it);
    result_t                 r;
    logic [DIFF_BITS-1:0]    diff;
    logic [63:0]             num;
    logic [63:0]             den;
    logic [63:0]             quo;
    logic [TIMEOUT_BITS-1:0] lim;
    logic [WHEEL_BITS-1:0]   ch;
    r  = '0;
    ch = it.wheel_channel;
    if (it.cmd == CMD_CAPTURE) begin
      idle_ticks = '0;
      // wrapped period; equal stamps mean one full counter turn
      diff = {1'b0, it.capture_value - cap_prev[ch]};
      if (diff == '0) diff = DIFF_BITS'(1) << COUNTER_BITS;
      num = 64'(hz_cfg) * 64'(SEC_PER_MIN);
      den = 64'(diff) * 64'(ppr_cfg);
      if (den == 64'd0) begin
        rpm_now[ch] = RPM_MAX;
      end else begin
        quo = num / den;
        rpm_now[ch] = (quo > 64'(RPM_MAX)) ? RPM_MAX : quo[RPM_BITS-1:0];
      end
      cap_prev[ch] = it.capture_value;
    end else begin
      // zero timeout acts as one
      lim = (tmo_cfg == '0) ? TIMEOUT_BITS'(1) : tmo_cfg;
      idle_ticks = idle_ticks + 1'b1;
      if (idle_ticks >= lim) begin
        for (int i = 0; i < NUM_WHEELS; i++) rpm_now[i] = '0;
        idle_ticks  = '0;
        r.timed_out = 1'b1;
      end
    end
    r.rpm_front_right = rpm_now[0];
    r.rpm_front_left  = rpm_now[1];
    r.rpm_rear_right  = rpm_now[2];
    r.rpm_rear_left   = rpm_now[3];
    return r;
  endfunction

  // mostly plausible periods per wheel, with ticks and random stamps mixed in
  function automatic item_t make_random_item();
    logic [WHEEL_BITS-1:0]   ch;
    logic [COUNTER_BITS-1:0] cap;
    ch = WHEEL_BITS'($urandom_range(NUM_WHEELS - 1));
    if ($urandom_range(99) < 25) return mk_item(CMD_TICK, ch, COUNTER_BITS'($urandom));
    case ($urandom_range(9))
      0:       cap = cap_prev[ch];
      1, 2:    cap = COUNTER_BITS'($urandom);
      3, 4:    cap = cap_prev[ch] + COUNTER_BITS'($urandom_range(1, 255));
      5, 6:    cap = cap_prev[ch] + COUNTER_BITS'($urandom_range(256, 4095));
      7, 8:    cap = cap_prev[ch] + COUNTER_BITS'($urandom_range(4096, 65535));
      default: cap = cap_prev[ch] + 1'b1;
    endcase
    return mk_item(CMD_CAPTURE, ch, cap);
  endfunction

  task automatic compare_field(input string fname, input logic [RPM_BITS-1:0] want,
                               input logic [RPM_BITS-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      err_cnt++;
    end
  endtask

  task automatic check_rpm_beat(input result_t got);
    result_t want;
    if (got.timed_out === 1'b1) n_timeout++;
    if (rpm_expect_q.size() == 0) begin
      $display("%0t: result beat with nothing expected, actual %h", $time, got);
      err_cnt++;
    end else begin
      want = rpm_expect_q.pop_front();
      compare_field("rpm_front_right", want.rpm_front_right, got.rpm_front_right);
      compare_field("rpm_front_left", want.rpm_front_left, got.rpm_front_left);
      compare_field("rpm_rear_right", want.rpm_rear_right, got.rpm_rear_right);
      compare_field("rpm_rear_left", want.rpm_rear_left, got.rpm_rear_left);
      compare_field("timed_out", RPM_BITS'(want.timed_out), RPM_BITS'(got.timed_out));
    end
  endtask

  // offer one beat with random gaps ahead of it, predict on accept
  task automatic send_item(input item_t it, input logic typed, input result_t want);
    result_t pred;
    cfg_we <= 1'b0;
    while (gaps_on && $urandom_range(99) < GAP_PCT) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall !== 1'b0) @(posedge clk);
    pred = predict_rpm_update(it);
    rpm_expect_q.push_back(typed ? want : pred);
    if (it.cmd == CMD_CAPTURE) n_capture++;
    else n_tick++;
  endtask

  // let every expected beat come back, then let the block drain
  task automatic wait_idle();
    item_valid <= 1'b0;
    cfg_we     <= 1'b0;
    while (rpm_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_reg(idx, data);
  endtask

  // result side: random stalls plus one long hold on request
  initial begin
    int hold_left;
    hold_left    = 0;
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        result_stall <= gaps_on && ($urandom_range(99) < GAP_PCT);
      end
    end
  end

  // score result beats
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && result_stall == 1'b0) check_rpm_beat(result);
  end

  // watchdog on cycles with no beat on any port
  always @(posedge clk) begin
    if ((item_valid && item_stall === 1'b0) || (result_valid === 1'b1 && !result_stall)
        || cfg_we)
      quiet_cnt = 0;
    else
      quiet_cnt++;
    if (quiet_cnt >= WDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, WDOG_LIMIT);
      $display("wheel_rpm_from_capture test failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    item_t                   it;
    int                      burst_left;
    logic [CLK_HZ_BITS-1:0]  hz;
    logic [PPR_BITS-1:0]     ppr;
    logic [TIMEOUT_BITS-1:0] tmo;

    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    burst_left = 0;
    rpm_state_reset();

    // directed table, reset register values first
    dir_rows.push_back(row_typed(mk_item(CMD_TICK, 2'd0, 16'h0000),
                                 mk_result('0, '0, '0, '0, 1'b0)));
    // first capture against a zero stamp, period of one count saturates
    dir_rows.push_back(row_typed(mk_item(CMD_CAPTURE, 2'd1, 16'h0001),
                                 mk_result('0, RPM_MAX, '0, '0, 1'b0)));
    dir_rows.push_back(row_item(mk_item(CMD_CAPTURE, 2'd0, 16'h0000)));
    dir_rows.push_back(row_item(mk_item(CMD_CAPTURE, 2'd1, 16'h0001)));
    dir_rows.push_back(row_item(mk_item(CMD_CAPTURE, 2'd2, 16'hFFFF)));
    dir_rows.push_back(row_item(mk_item(CMD_CAPTURE, 2'd2, 16'h0000)));
    dir_rows.push_back(row_item(mk_item(CMD_CAPTURE, 2'd3, 16'h8000)));
    dir_rows.push_back(row_item(mk_item(CMD_CAPTURE, 2'd3, 16'h7FFF)));
    dir_rows.push_back(row_item(mk_item(CMD_TICK, 2'd3, 16'hFFFF)));
    // every tick times out
    dir_rows.push_back(row_reg(REG_TIMEOUT, 28'd1));
    dir_rows.push_back(row_typed(mk_item(CMD_TICK, 2'd2, 16'h5555),
                                 mk_result('0, '0, '0, '0, 1'b1)));
    dir_rows.push_back(row_item(mk_item(CMD_CAPTURE, 2'd0, 16'h1234)));
    // zero timeout behaves like one
    dir_rows.push_back(row_reg(REG_TIMEOUT, 28'hFFF0000));
    dir_rows.push_back(row_typed(mk_item(CMD_TICK, 2'd1, 16'hAAAA),
                                 mk_result('0, '0, '0, '0, 1'b1)));
    // a capture restarts the idle count
    dir_rows.push_back(row_reg(REG_TIMEOUT, 28'd3));
    dir_rows.push_back(row_item(mk_item(CMD_TICK, 2'd0, 16'h0000)));
    dir_rows.push_back(row_item(mk_item(CMD_TICK, 2'd0, 16'h0000)));
    dir_rows.push_back(row_item(mk_item(CMD_CAPTURE, 2'd1, 16'hFFFF)));
    dir_rows.push_back(row_item(mk_item(CMD_TICK, 2'd0, 16'h0000)));
    dir_rows.push_back(row_item(mk_item(CMD_TICK, 2'd0, 16'h0000)));
    dir_rows.push_back(row_typed(mk_item(CMD_TICK, 2'd0, 16'h0000),
                                 mk_result('0, '0, '0, '0, 1'b1)));
    // zero clock gives zero rpm
    dir_rows.push_back(row_reg(REG_CLOCK_HZ, 28'd0));
    dir_rows.push_back(row_item(mk_item(CMD_CAPTURE, 2'd2, 16'h4000)));
    // full clock with zero pulses saturates
    dir_rows.push_back(row_reg(REG_CLOCK_HZ, 28'hFFFFFFF));
    dir_rows.push_back(row_reg(REG_PULSES, 28'hFFFFF00));
    dir_rows.push_back(row_item(mk_item(CMD_CAPTURE, 2'd3, 16'h1000)));
    dir_rows.push_back(row_reg(REG_PULSES, 28'd255));
    dir_rows.push_back(row_item(mk_item(CMD_CAPTURE, 2'd0, 16'h1234)));
    // write to an unused index changes nothing
    dir_rows.push_back(row_reg(REG_UNUSED, 28'hFFFFFFF));
    dir_rows.push_back(row_item(mk_item(CMD_CAPTURE, 2'd1, 16'h0000)));
    dir_rows.push_back(row_reg(REG_CLOCK_HZ, 28'd200000000));
    dir_rows.push_back(row_reg(REG_PULSES, 28'd1));
    dir_rows.push_back(row_reg(REG_TIMEOUT, 28'd65535));
    dir_rows.push_back(row_item(mk_item(CMD_CAPTURE, 2'd2, 16'h4001)));
    dir_rows.push_back(row_item(mk_item(CMD_TICK, 2'd3, 16'h0F0F)));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // walk the directed table
    n_setting++;
    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_reg) write_reg(dir_rows[k].idx, dir_rows[k].data);
      else send_item(dir_rows[k].it, dir_rows[k].typed, dir_rows[k].want);
    end

    // random phases, each under its own register setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          hz  = 28'hFFFFFFF;
          ppr = 8'd255;
          tmo = 16'hFFFF;
        end
        1: begin
          hz  = 28'd1;
          ppr = 8'd1;
          tmo = 16'd1;
        end
        default: begin
          case ($urandom_range(3))
            0:       hz = 28'd1000000;
            1:       hz = 28'd200000000;
            2:       hz = CLK_HZ_BITS'($urandom_range(1, 20000000));
            default: hz = CLK_HZ_BITS'($urandom);
          endcase
          case ($urandom_range(4))
            0:       ppr = 8'd1;
            1:       ppr = 8'd0;
            default: ppr = PPR_BITS'($urandom_range(1, 255));
          endcase
          if ($urandom_range(3) == 0) tmo = TIMEOUT_BITS'($urandom);
          else tmo = TIMEOUT_BITS'($urandom_range(0, 12));
        end
      endcase
      write_reg(REG_CLOCK_HZ, hz);
      write_reg(REG_PULSES, {20'($urandom), ppr});
      write_reg(REG_TIMEOUT, {12'($urandom), tmo});
      write_reg(REG_UNUSED, CFG_DATA_BITS'($urandom));
      n_setting++;
      // one phase runs with no gaps on either side
      gaps_on = (p != 4);

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // long result hold while beats keep coming
        if (p == 2 && n == 100) hold_req = 1'b1;
        if (burst_left == 0 && $urandom_range(99) < 2) burst_left = $urandom_range(1, 24);
        if (burst_left != 0) begin
          it = mk_item(CMD_TICK, WHEEL_BITS'($urandom), COUNTER_BITS'($urandom));
          burst_left--;
        end else begin
          it = make_random_item();
        end
        send_item(it, 1'b0, '0);
      end
    end

    wait_idle();
    $display("covered %0d capture and %0d tick beats under %0d register settings",
             n_capture, n_tick, n_setting);
    $display("%0d timeouts seen, %0d mismatches", n_timeout, err_cnt);
    if (err_cnt == 0) begin
      $display("wheel_rpm_from_capture test passed");
    end else begin
      $display("wheel_rpm_from_capture test failed");
    end
    $finish;
  end

endmodule
